// ===== sv/ehc_pkg.sv =====
// shared types, codes and helper functions of the escape hex codec
package ehc_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int MAX_RESULTS = 4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DIRECTION       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE_CHAR     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_CAPACITY = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_BAD_HEX   = 2'd2;
   localparam logic [1:0] ST_TRUNCATED = 2'd3;

   localparam logic [7:0] ESCAPE_RESET   = 8'h25;
   localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;
   localparam logic [7:0] PRINT_LOW      = 8'h20;
   localparam logic [7:0] PRINT_HIGH     = 8'h7E;

   typedef enum logic [1:0] {
      PH_NORMAL,
      PH_ESCAPE,
      PH_LOW_DIGIT
   } phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic [1:0] status;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } digit_type;

   // upper-case hex digit for a nibble
   function automatic logic [7:0] hex_char(input logic [3:0] v);
      logic [7:0] c;
      if (v < 4'd10) begin
         c = 8'h30 + {4'd0, v};
      end else begin
         c = 8'h37 + {4'd0, v};
      end
      return c;
   endfunction

   // value of a hex digit in either case
   function automatic digit_type digit_value(input logic [7:0] c);
      digit_type d;
      d = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.ok    = 1'b1;
         d.value = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         d.ok    = 1'b1;
         d.value = c[3:0] + 4'd9;
      end
      return d;
   endfunction

endpackage

// ===== sv/ehc_if.sv =====
// channel interfaces of the escape hex codec: request, response and register write
interface ehc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface ehc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   logic [1:0] status;

   modport source (output valid, output out_byte, output out_last, output status,
                   input ready);
   modport sink   (input valid, input out_byte, input out_last, input status,
                   output ready);
endinterface

interface ehc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/escape_hex_codec_core.sv =====
// top level of the escape hex codec
// Encodes a byte stream into percent-style hex escaped text or decodes such text back
// to bytes, as set by the direction register, with a programmable escape byte and a
// per-stream output byte limit. Each accepted byte is registered, all its results
// (up to four: three encoded bytes and a terminator) are formed together into a
// result buffer, and the buffer drains one result per cycle while the response
// channel is ready. When encoding, a plain byte gives one result, the escape byte
// two, a byte encoded as hex three, and such a byte at the end of a stream four. A
// request byte passes through the input register and then the result buffer before
// its first response. Registers may be written only while no stream data is in
// flight; a register write is always taken.
module escape_hex_codec_core #(
   parameter int COUNT_WIDTH = 16
) (
   input logic      clock,
   input logic      reset,
   ehc_req_if.sink  req_bus,
   ehc_rsp_if.source rsp_bus,
   ehc_csr_if.sink  csr_bus
);
   import ehc_pkg::*;

   localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
   localparam int SUM_W = CMP_W + 1;

   logic                   direction_ff;
   logic [7:0]             escape_ff;
   logic [15:0]            capacity_ff;

   phase_type              phase_ff, phase_in;
   logic [3:0]             nibble_ff, nibble_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   halted_ff, halted_in;

   logic                   in_valid_ff;
   logic [7:0]             in_byte_ff;
   logic                   in_last_ff;

   result_type             res_ff [MAX_RESULTS];
   result_type             res_in [MAX_RESULTS];
   logic [2:0]             res_cnt_ff, res_cnt_in;
   logic [2:0]             res_idx_ff;

   logic [CMP_W-1:0]       limit;
   logic [3:0]             room;
   logic                   busy, take, free, process;

   logic [7:0]             seq [3];
   logic [1:0]             seq_len;
   logic [1:0]             n_data;
   logic                   stop;
   digit_type              digit;

   // effective byte limit: smaller of the capacity and the counter maximum
   always_comb begin
      logic [CMP_W-1:0] cnt_max, cap_ext;
      cnt_max = CMP_W'({COUNT_WIDTH{1'b1}});
      cap_ext = CMP_W'(capacity_ff);
      limit   = (cap_ext < cnt_max) ? cap_ext : cnt_max;
      for (int k = 0; k < 4; k++) begin
         room[k] = (SUM_W'(count_ff) + SUM_W'(k)) < SUM_W'(limit);
      end
   end

   assign digit = digit_value(in_byte_ff);

   // encode sequence for the registered byte
   always_comb begin
      seq[0]  = in_byte_ff;
      seq[1]  = escape_ff;
      seq[2]  = escape_ff;
      seq_len = 2'd1;
      if (in_byte_ff >= PRINT_LOW && in_byte_ff <= PRINT_HIGH) begin
         if (in_byte_ff == escape_ff) begin
            seq[0]  = escape_ff;
            seq_len = 2'd2;
         end
      end else begin
         seq[0]  = escape_ff;
         seq[1]  = hex_char(in_byte_ff[7:4]);
         seq[2]  = hex_char(in_byte_ff[3:0]);
         seq_len = 2'd3;
      end
   end

   // results and next stream state for the registered byte
   always_comb begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         res_in[k] = '0;
      end
      res_cnt_in = 3'd0;
      phase_in   = phase_ff;
      nibble_in  = nibble_ff;
      halted_in  = halted_ff;
      n_data     = 2'd0;
      stop       = 1'b0;

      if (halted_ff) begin
         // drop until end of stream
      end else if (!direction_ff) begin
         for (int k = 0; k < 3; k++) begin
            if (k < int'(seq_len) && !stop) begin
               if (!room[k]) begin
                  res_in[res_cnt_in[1:0]] = '{data: 8'd0, last: 1'b1, status: ST_OVERFLOW};
                  stop = 1'b1;
               end else begin
                  res_in[res_cnt_in[1:0]] = '{data: seq[k], last: 1'b0, status: ST_OK};
                  n_data = n_data + 2'd1;
               end
               res_cnt_in = res_cnt_in + 3'd1;
            end
         end
         if (stop) begin
            halted_in = 1'b1;
         end else if (in_last_ff) begin
            if (room[seq_len]) begin
               res_in[res_cnt_in[1:0]] = '{data: 8'd0, last: 1'b1, status: ST_OK};
               res_cnt_in = res_cnt_in + 3'd1;
            end else begin
               res_in[res_cnt_in[1:0] - 2'd1].last = 1'b1;
            end
         end
      end else begin
         unique case (phase_ff)
            PH_NORMAL: begin
               if (in_byte_ff == 8'd0) begin
                  res_in[0]  = '{data: 8'd0, last: 1'b1, status: ST_OK};
                  res_cnt_in = 3'd1;
                  halted_in  = 1'b1;
               end else if (!room[0]) begin
                  res_in[0]  = '{data: 8'd0, last: 1'b1, status: ST_OVERFLOW};
                  res_cnt_in = 3'd1;
                  halted_in  = 1'b1;
               end else if (in_byte_ff == escape_ff) begin
                  if (in_last_ff) begin
                     res_in[0]  = '{data: 8'd0, last: 1'b1, status: ST_TRUNCATED};
                     res_cnt_in = 3'd1;
                  end else begin
                     phase_in = PH_ESCAPE;
                  end
               end else begin
                  res_in[0]  = '{data: in_byte_ff, last: in_last_ff, status: ST_OK};
                  res_cnt_in = 3'd1;
                  n_data     = 2'd1;
               end
            end
            PH_ESCAPE: begin
               if (in_byte_ff == escape_ff) begin
                  res_in[0]  = '{data: escape_ff, last: in_last_ff, status: ST_OK};
                  res_cnt_in = 3'd1;
                  n_data     = 2'd1;
                  phase_in   = PH_NORMAL;
               end else if (!digit.ok) begin
                  res_in[0]  = '{data: 8'd0, last: 1'b1, status: ST_BAD_HEX};
                  res_cnt_in = 3'd1;
                  halted_in  = 1'b1;
               end else if (in_last_ff) begin
                  res_in[0]  = '{data: 8'd0, last: 1'b1, status: ST_TRUNCATED};
                  res_cnt_in = 3'd1;
               end else begin
                  nibble_in = digit.value;
                  phase_in  = PH_LOW_DIGIT;
               end
            end
            PH_LOW_DIGIT: begin
               if (!digit.ok) begin
                  res_in[0]  = '{data: 8'd0, last: 1'b1, status: ST_BAD_HEX};
                  res_cnt_in = 3'd1;
                  halted_in  = 1'b1;
               end else begin
                  res_in[0]  = '{data: {nibble_ff, digit.value}, last: in_last_ff,
                                 status: ST_OK};
                  res_cnt_in = 3'd1;
                  n_data     = 2'd1;
                  phase_in   = PH_NORMAL;
               end
            end
            default: begin
               phase_in = PH_NORMAL;
            end
         endcase
      end

      count_in = count_ff + COUNT_WIDTH'(n_data);

      // end of stream clears all stream state
      if (in_last_ff) begin
         phase_in  = PH_NORMAL;
         nibble_in = 4'd0;
         count_in  = '0;
         halted_in = 1'b0;
      end
   end

   // handshake control
   assign busy    = res_idx_ff < res_cnt_ff;
   assign take    = rsp_bus.valid && rsp_bus.ready;
   assign free    = !busy || (take && (res_idx_ff + 3'd1 == res_cnt_ff));
   assign process = in_valid_ff && free;

   assign req_bus.ready    = !in_valid_ff || process;
   assign csr_bus.ready    = 1'b1;
   assign rsp_bus.valid    = busy;
   assign rsp_bus.out_byte = res_ff[res_idx_ff[1:0]].data;
   assign rsp_bus.out_last = res_ff[res_idx_ff[1:0]].last;
   assign rsp_bus.status   = res_ff[res_idx_ff[1:0]].status;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         escape_ff    <= ESCAPE_RESET;
         capacity_ff  <= CAPACITY_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_DIRECTION:       direction_ff <= csr_bus.data[0];
            CSR_ESCAPE_CHAR:     escape_ff    <= csr_bus.data[7:0];
            CSR_OUTPUT_CAPACITY: capacity_ff  <= csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   // stream state, input register and result buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_NORMAL;
         nibble_ff   <= 4'd0;
         count_ff    <= '0;
         halted_ff   <= 1'b0;
         in_valid_ff <= 1'b0;
         res_cnt_ff  <= 3'd0;
         res_idx_ff  <= 3'd0;
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (process) begin
            phase_ff   <= phase_in;
            nibble_ff  <= nibble_in;
            count_ff   <= count_in;
            halted_ff  <= halted_in;
            res_cnt_ff <= res_cnt_in;
            res_idx_ff <= 3'd0;
         end else if (take) begin
            res_idx_ff <= res_idx_ff + 3'd1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.in_byte;
         in_last_ff <= req_bus.in_last;
      end
      if (process) begin
         for (int k = 0; k < MAX_RESULTS; k++) begin
            res_ff[k] <= res_in[k];
         end
      end
   end

endmodule

// ===== test/tb.sv =====
// testbench for escape_hex_codec_core: directed and random byte streams checked against a predictor
`timescale 1ns / 1ps

module tb;
   import ehc_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   logic clock = 1'b0;
   logic reset;

   ehc_req_if req_bus ();
   ehc_rsp_if rsp_bus ();
   ehc_csr_if csr_bus ();

   escape_hex_codec_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #6 clock = ~clock;

   string HEX_UP  = "0123456789ABCDEF";
   string HEX_LOW = "0123456789abcdef";

   // codec state as the block should hold it
   logic        dir_q;
   logic [7:0]  esc_q;
   logic [15:0] cap_q;
   phase_type   ph_q;
   logic [3:0]  hi_q;
   logic [15:0] cnt_q;
   logic        halt_q;

   result_type pending_out_q[$];
   result_type due_item;
   int         fault_count = 0;
   int         cycle_count;
   int         rsp_hold;
   bit         calm = 1'b0;

   function automatic int draw_wait();
      return calm ? 0 : int'($urandom_range(0, 7));
   endfunction

   function automatic void push_out(input logic [7:0] d, input logic l, input logic [1:0] s);
      result_type r;
      r.data   = d;
      r.last   = l;
      r.status = s;
      pending_out_q.push_back(r);
   endfunction

   function automatic void close_stream();
      ph_q   = PH_NORMAL;
      hi_q   = 4'd0;
      cnt_q  = 16'd0;
      halt_q = 1'b0;
   endfunction

   function automatic void fail_stream(input logic [1:0] s, input logic l);
      push_out(8'h00, 1'b1, s);
      if (l) begin
         close_stream();
      end else begin
         halt_q = 1'b1;
      end
   endfunction

   function automatic int hex_value(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
      if (c >= 8'h61 && c <= 8'h66) return 10 + c - 8'h61;
      if (c >= 8'h41 && c <= 8'h46) return 10 + c - 8'h41;
      return -1;
   endfunction

   function automatic void encode_byte(input logic [7:0] b, input logic l);
      logic [7:0] seq [3];
      int         m;
      result_type r;
      if (b >= PRINT_LOW && b <= PRINT_HIGH) begin
         seq[0] = b;
         seq[1] = b;
         seq[2] = b;
         m = (b == esc_q) ? 2 : 1;
      end else begin
         seq[0] = esc_q;
         seq[1] = HEX_UP[b[7:4]];
         seq[2] = HEX_UP[b[3:0]];
         m = 3;
      end
      for (int k = 0; k < m; k++) begin
         if (cnt_q >= cap_q) begin
            fail_stream(ST_OVERFLOW, l);
            return;
         end
         push_out(seq[k], 1'b0, ST_OK);
         cnt_q++;
      end
      if (l) begin
         if (cnt_q < cap_q) begin
            push_out(8'h00, 1'b1, ST_OK);
         end else begin
            r = pending_out_q.pop_back();
            r.last = 1'b1;
            pending_out_q.push_back(r);
         end
         close_stream();
      end
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic l);
      int d;
      if (ph_q == PH_NORMAL) begin
         if (b == 8'h00) begin
            push_out(8'h00, 1'b1, ST_OK);
            if (l) close_stream();
            else halt_q = 1'b1;
            return;
         end
         if (cnt_q >= cap_q) begin
            fail_stream(ST_OVERFLOW, l);
            return;
         end
         if (b == esc_q) begin
            if (l) fail_stream(ST_TRUNCATED, 1'b1);
            else ph_q = PH_ESCAPE;
            return;
         end
         push_out(b, l, ST_OK);
         cnt_q++;
      end else if (ph_q == PH_ESCAPE) begin
         if (b == esc_q) begin
            push_out(esc_q, l, ST_OK);
            cnt_q++;
            ph_q = PH_NORMAL;
         end else begin
            d = hex_value(b);
            if (d < 0) begin
               fail_stream(ST_BAD_HEX, l);
               return;
            end
            if (l) begin
               fail_stream(ST_TRUNCATED, 1'b1);
               return;
            end
            hi_q = d[3:0];
            ph_q = PH_LOW_DIGIT;
            return;
         end
      end else begin
         d = hex_value(b);
         if (d < 0) begin
            fail_stream(ST_BAD_HEX, l);
            return;
         end
         push_out({hi_q, d[3:0]}, l, ST_OK);
         cnt_q++;
         ph_q = PH_NORMAL;
      end
      if (l) close_stream();
   endfunction

   function automatic void code_byte(input logic [7:0] b, input logic l);
      if (halt_q) begin
         if (l) close_stream();
      end else if (dir_q == 1'b0) begin
         encode_byte(b, l);
      end else begin
         decode_byte(b, l);
      end
   endfunction

   // check each result transfer, track register writes, predict each accepted byte
   always @(posedge clock) begin
      if (reset) begin
         dir_q = 1'b0;
         esc_q = ESCAPE_RESET;
         cap_q = CAPACITY_RESET;
         close_stream();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_out_q.size() == 0) begin
               $error("unexpected transfer: out_byte %h out_last %b status %0d",
                      rsp_bus.out_byte, rsp_bus.out_last, rsp_bus.status);
               fault_count++;
            end else begin
               due_item = pending_out_q.pop_front();
               if (rsp_bus.out_byte !== due_item.data) begin
                  $error("out_byte mismatch: expected %h, actual %h",
                         due_item.data, rsp_bus.out_byte);
                  fault_count++;
               end
               if (rsp_bus.out_last !== due_item.last) begin
                  $error("out_last mismatch: expected %b, actual %b",
                         due_item.last, rsp_bus.out_last);
                  fault_count++;
               end
               if (rsp_bus.status !== due_item.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         due_item.status, rsp_bus.status);
                  fault_count++;
               end
            end
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_DIRECTION:       dir_q = csr_bus.data[0];
               CSR_ESCAPE_CHAR:     esc_q = csr_bus.data[7:0];
               CSR_OUTPUT_CAPACITY: cap_q = csr_bus.data;
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) code_byte(req_bus.in_byte, req_bus.in_last);
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold = 0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) rsp_hold = draw_wait();
         if (rsp_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic l);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= b;
      req_bus.in_last <= l;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_text(input string s, input logic ends);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], ends && i == s.len() - 1);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_out_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic reconfigure();
      logic [7:0]  e;
      logic [15:0] c;
      wait_drained();
      case ($urandom_range(0, 3))
         0:       e = ESCAPE_RESET;
         1:       e = 8'($urandom_range(32, 126));
         2:       e = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         default: e = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 3))
         0:       c = 16'($urandom_range(0, 24));
         1:       c = 16'($urandom_range(25, 65534));
         default: c = CAPACITY_RESET;
      endcase
      write_csr(CSR_DIRECTION, 16'($urandom_range(0, 1)));
      write_csr(CSR_ESCAPE_CHAR, {8'h00, e});
      write_csr(CSR_OUTPUT_CAPACITY, c);
   endtask

   task automatic test_encode_defaults();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h20, 1'b0);
      send_byte(8'h7E, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(ESCAPE_RESET, 1'b0);
      send_byte(8'h41, 1'b1);
   endtask

   task automatic test_encode_limits();
      wait_drained();
      write_csr(CSR_OUTPUT_CAPACITY, 16'd4);
      send_byte(8'h01, 1'b0);
      send_byte(8'h41, 1'b1);
      wait_drained();
      write_csr(CSR_OUTPUT_CAPACITY, 16'd0);
      send_text("xy", 1'b1);
      wait_drained();
      write_csr(CSR_OUTPUT_CAPACITY, CAPACITY_RESET);
      write_csr(CSR_ESCAPE_CHAR, 16'h00FF);
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic test_decode_cases();
      wait_drained();
      write_csr(CSR_DIRECTION, 16'd1);
      write_csr(CSR_ESCAPE_CHAR, {8'h00, ESCAPE_RESET});
      send_text("%%%aF", 1'b1);
      send_text("%Gq", 1'b1);
      send_text("%4", 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b0);
      send_text("n", 1'b1);
      send_text("%", 1'b1);
      send_text("%7", 1'b1);
      wait_drained();
      write_csr(CSR_OUTPUT_CAPACITY, 16'd1);
      send_text("ab", 1'b1);
   endtask

   task automatic test_random_streams();
      logic [7:0] text_q[$];
      logic [7:0] v;
      int         n;
      int         sent;
      bit         noisy;
      sent = 0;
      while (sent < 400) begin
         if (sent == 0 || $urandom_range(0, 2) == 0) reconfigure();
         calm  = ($urandom_range(0, 4) == 0);
         noisy = ($urandom_range(0, 6) == 0);
         n = $urandom_range(1, 12);
         text_q.delete();
         while (text_q.size() < n) begin
            v = 8'($urandom_range(0, 255));
            if (dir_q == 1'b0 || noisy) begin
               case ($urandom_range(0, 3))
                  0:       text_q.push_back(esc_q);
                  1:       text_q.push_back(noisy ? HEX_LOW[v[3:0]] : 8'($urandom_range(32, 126)));
                  2:       text_q.push_back(noisy ? 8'h00 : v);
                  default: text_q.push_back(v);
               endcase
            end else begin
               case ($urandom_range(0, 3))
                  0: begin
                     while (v == 8'h00 || v == esc_q) v = 8'($urandom_range(1, 255));
                     text_q.push_back(v);
                  end
                  1: begin
                     text_q.push_back(esc_q);
                     text_q.push_back(esc_q);
                  end
                  default: begin
                     text_q.push_back(esc_q);
                     text_q.push_back($urandom_range(0, 1) ? HEX_UP[v[7:4]] : HEX_LOW[v[7:4]]);
                     text_q.push_back($urandom_range(0, 1) ? HEX_UP[v[3:0]] : HEX_LOW[v[3:0]]);
                  end
               endcase
            end
         end
         // cut off inside an escape
         if (dir_q == 1'b1 && !noisy && $urandom_range(0, 7) == 0) begin
            text_q.push_back(esc_q);
            if ($urandom_range(0, 1)) text_q.push_back(HEX_UP[v[3:0]]);
         end
         foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
         sent += text_q.size();
      end
      calm = 1'b0;
   endtask

   initial begin
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.in_byte <= 8'h00;
      req_bus.in_last <= 1'b0;
      csr_bus.valid   <= 1'b0;
      csr_bus.index   <= CSR_DIRECTION;
      csr_bus.data    <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_encode_defaults();
      test_encode_limits();
      test_decode_cases();
      test_random_streams();
      wait_drained();
      repeat (16) @(posedge clock);
      if (fault_count == 0 && pending_out_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
